// File: rtl/ffha_pkg.sv
// Shared types, widths and codes for the first-fit heap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ffha_pkg;

   localparam int ADDR_W          = 48;
   localparam int LEN_W           = 41;
   localparam int STAT_W          = 3;
   localparam int SEG_DEPTH       = 1024;
   localparam int IDX_W           = $clog2(SEG_DEPTH);
   localparam int CNT_W           = $clog2(SEG_DEPTH + 1);
   localparam int WIDE_W          = LEN_W + 2;
   localparam int HEADER_BYTES    = 24;
   localparam int GRANULE_BYTES   = 16;
   localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = ADDR_W'(64'h40_0000);

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 3'd0,
      ST_ZERO_SIZE  = 3'd1,
      ST_NO_MEMORY  = 3'd2,
      ST_BAD_ADDR   = 3'd3,
      ST_NOT_SEG    = 3'd4,
      ST_DOUBLE     = 3'd5,
      ST_TABLE_FULL = 3'd6
   } status_type;

   typedef enum logic {
      CSR_HEAP_BASE  = 1'b0,
      CSR_HEAP_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      RS_IDX  = 2'd0,
      RS_NEXT = 2'd1,
      RS_SRC  = 2'd2
   } rd_sel_type;

   typedef enum logic [2:0] {
      WK_NONE      = 3'd0,
      WK_SHIFT     = 3'd1,
      WK_REMAINDER = 3'd2,
      WK_ALLOC_SZ  = 3'd3,
      WK_ALLOC_CUR = 3'd4,
      WK_APPEND    = 3'd5,
      WK_MERGE     = 3'd6
   } wr_kind_type;

   typedef struct packed {
      logic               operation;
      logic [LEN_W-1:0]   request_bytes;
      logic [ADDR_W-1:0]  release_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  payload_address;
      logic [STAT_W-1:0]  status;
      logic [LEN_W-1:0]   used_total;
      logic [LEN_W-1:0]   free_total;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic               free;
   } seg_type;

   typedef struct packed {
      logic         latch_req;
      logic         prep;
      logic         scan_init;
      logic         scan_adv;
      logic         hit_latch;
      logic         addr_latch;
      logic         rem_latch;
      logic         shift_init_up;
      logic         shift_step_up;
      logic         shift_init_down;
      logic         shift_step_down;
      logic         merge_next;
      logic         merge_prev;
      logic         count_inc;
      logic         count_sub;
      logic         used_add_cur;
      logic         used_add_size;
      logic         used_sub_cur;
      logic         set_status;
      status_type   status_code;
      logic         rd_en;
      rd_sel_type   rd_sel;
      wr_kind_type  wr_kind;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_free_op;
      logic zero;
      logic big;
      logic bad;
      logic at_end;
      logic alloc_hit;
      logic addr_match;
      logic rd_free;
      logic split_ok;
      logic up_empty;
      logic up_last;
      logic table_full;
      logic append_fits;
      logic next_exists;
      logic down_empty;
   } stat_type;

endpackage

// File: rtl/ffha_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ffha_datapath.sv
// Datapath of the allocator: segment table RAM, scan offset, shift pointers,
// byte accounting, configuration registers and the result register. Uses ffha_pkg.
`timescale 1ns / 1ps

module ffha_datapath import ffha_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  req_type             req_data,
   input  logic                csr_wr,
   input  logic                csr_index,
   input  logic [ADDR_W-1:0]   csr_wdata,
   output rsp_type             rsp_data
);

   localparam logic [LEN_W-1:0]  HDR_L  = LEN_W'(HEADER_BYTES);
   localparam logic [WIDE_W-1:0] HDR_W  = WIDE_W'(HEADER_BYTES);
   localparam logic [WIDE_W-1:0] GRAN_W = WIDE_W'(GRANULE_BYTES);
   localparam logic [WIDE_W-1:0] GMASK  = WIDE_W'(GRANULE_BYTES - 1);

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [LEN_W-1:0]  bytes_ff, bytes_in;
   logic              op_ff, op_in;
   logic [LEN_W-1:0]  reqb_ff, reqb_in;
   logic [ADDR_W-1:0] rel_ff, rel_in;
   logic [LEN_W:0]    size_ff, size_in;
   logic [LEN_W-1:0]  target_ff, target_in;
   logic              zero_ff, zero_in;
   logic              bad_ff, bad_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  off_ff, off_in;
   logic              prev_free_ff, prev_free_in;
   logic [LEN_W-1:0]  prev_len_ff, prev_len_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic [LEN_W-1:0]  merge_ff, merge_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [1:0]        removed_ff, removed_in;
   logic [CNT_W-1:0]  mdst_ff, mdst_in;
   logic [CNT_W-1:0]  src_ff, src_in;
   logic [CNT_W-1:0]  dst_ff, dst_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   status_type        status_ff, status_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  used_ff, used_in;
   rsp_type           rsp_ff, rsp_in;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [$bits(seg_type)-1:0] rd_raw;
   seg_type           rd_seg;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   seg_type           wr_seg;

   logic [LEN_W-1:0]  free_now;
   logic [CNT_W-1:0]  idx_next;
   logic [WIDE_W-1:0] give;
   logic [ADDR_W:0]   lo_bound;
   logic [ADDR_W:0]   hi_bound;
   logic [WIDE_W-1:0] rounded;

   ffha_ram #(
      .WIDTH ($bits(seg_type)),
      .DEPTH (SEG_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_seg),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_seg   = seg_type'(rd_raw);
   assign free_now = (bytes_ff > used_ff) ? (bytes_ff - used_ff) : '0;
   assign idx_next = idx_ff + CNT_W'(1);
   assign give     = HDR_W + WIDE_W'(cur_len_ff);
   assign lo_bound = (ADDR_W + 1)'(base_ff) + (ADDR_W + 1)'(HEADER_BYTES);
   assign hi_bound = (ADDR_W + 1)'(base_ff) + (ADDR_W + 1)'(bytes_ff);
   assign rounded  = (WIDE_W'(reqb_ff) + GMASK) & ~GMASK;

   // Table port steering.
   always_comb begin
      rd_en = cmd.rd_en;
      case (cmd.rd_sel)
         RS_IDX:  rd_addr = idx_ff[IDX_W-1:0];
         RS_NEXT: rd_addr = idx_next[IDX_W-1:0];
         RS_SRC:  rd_addr = src_ff[IDX_W-1:0];
         default: rd_addr = idx_ff[IDX_W-1:0];
      endcase
      wr_en   = 1'b1;
      wr_addr = idx_ff[IDX_W-1:0];
      wr_seg  = '{len: cur_len_ff, free: 1'b0};
      unique case (cmd.wr_kind)
         WK_NONE: begin
            wr_en = 1'b0;
         end
         WK_SHIFT: begin
            wr_addr = dst_ff[IDX_W-1:0];
            wr_seg  = rd_seg;
         end
         WK_REMAINDER: begin
            wr_addr = idx_next[IDX_W-1:0];
            wr_seg  = '{len: rem_ff, free: 1'b1};
         end
         WK_ALLOC_SZ: begin
            wr_seg  = '{len: size_ff[LEN_W-1:0], free: 1'b0};
         end
         WK_ALLOC_CUR: begin
            wr_seg  = '{len: cur_len_ff, free: 1'b0};
         end
         WK_APPEND: begin
            wr_addr = count_ff[IDX_W-1:0];
            wr_seg  = '{len: size_ff[LEN_W-1:0], free: 1'b0};
         end
         WK_MERGE: begin
            wr_addr = mdst_ff[IDX_W-1:0];
            wr_seg  = '{len: merge_ff, free: 1'b1};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      base_in      = base_ff;
      bytes_in     = bytes_ff;
      op_in        = op_ff;
      reqb_in      = reqb_ff;
      rel_in       = rel_ff;
      size_in      = size_ff;
      target_in    = target_ff;
      zero_in      = zero_ff;
      bad_in       = bad_ff;
      idx_in       = idx_ff;
      off_in       = off_ff;
      prev_free_in = prev_free_ff;
      prev_len_in  = prev_len_ff;
      cur_len_in   = cur_len_ff;
      merge_in     = merge_ff;
      rem_in       = rem_ff;
      removed_in   = removed_ff;
      mdst_in      = mdst_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      addr_in      = addr_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      rsp_in       = rsp_ff;

      if (csr_wr) begin
         if (csr_index == CSR_HEAP_BASE) begin
            base_in = csr_wdata;
         end else begin
            bytes_in = csr_wdata[LEN_W-1:0];
         end
      end
      if (cmd.latch_req) begin
         op_in   = req_data.operation;
         reqb_in = req_data.request_bytes;
         rel_in  = req_data.release_address;
      end
      if (cmd.prep) begin
         size_in   = rounded[LEN_W:0];
         zero_in   = (reqb_ff == '0);
         bad_in    = (rel_ff == '0) || ((ADDR_W + 1)'(rel_ff) < lo_bound)
                     || ((ADDR_W + 1)'(rel_ff) >= hi_bound);
         // Only meaningful when the address is in range, where it is below heap_bytes.
         target_in = LEN_W'(rel_ff - base_ff - ADDR_W'(HEADER_BYTES));
      end
      if (cmd.scan_init) begin
         idx_in       = '0;
         off_in       = '0;
         prev_free_in = 1'b0;
      end
      if (cmd.scan_adv) begin
         off_in       = off_ff + HDR_L + rd_seg.len;
         idx_in       = idx_next;
         prev_free_in = rd_seg.free;
         prev_len_in  = rd_seg.len;
      end
      if (cmd.hit_latch) begin
         cur_len_in = rd_seg.len;
         merge_in   = rd_seg.len;
         removed_in = '0;
      end
      if (cmd.addr_latch) begin
         addr_in = base_ff + ADDR_W'(off_ff) + ADDR_W'(HEADER_BYTES);
      end
      if (cmd.rem_latch) begin
         rem_in = cur_len_ff - size_ff[LEN_W-1:0] - HDR_L;
      end
      if (cmd.shift_init_up) begin
         src_in = count_ff - CNT_W'(1);
         dst_in = count_ff;
      end
      if (cmd.shift_step_up) begin
         src_in = src_ff - CNT_W'(1);
         dst_in = dst_ff - CNT_W'(1);
      end
      if (cmd.shift_init_down) begin
         dst_in = mdst_ff + CNT_W'(1);
         src_in = mdst_ff + CNT_W'(1) + CNT_W'(removed_ff);
      end
      if (cmd.shift_step_down) begin
         src_in = src_ff + CNT_W'(1);
         dst_in = dst_ff + CNT_W'(1);
      end
      if (cmd.merge_next && rd_seg.free) begin
         merge_in   = merge_ff + HDR_L + rd_seg.len;
         removed_in = removed_ff + 2'd1;
      end
      if (cmd.merge_prev) begin
         if (prev_free_ff) begin
            merge_in   = prev_len_ff + HDR_L + merge_ff;
            mdst_in    = idx_ff - CNT_W'(1);
            removed_in = removed_ff + 2'd1;
         end else begin
            mdst_in = idx_ff;
         end
      end
      if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.count_sub) begin
         count_in = count_ff - CNT_W'(removed_ff);
      end
      if (cmd.used_add_cur) begin
         used_in = used_ff + HDR_L + cur_len_ff;
      end
      if (cmd.used_add_size) begin
         used_in = used_ff + HDR_L + size_ff[LEN_W-1:0];
      end
      if (cmd.used_sub_cur) begin
         used_in = (WIDE_W'(used_ff) > give) ? LEN_W'(WIDE_W'(used_ff) - give) : '0;
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.rsp_load) begin
         // Only a granted allocation carries an address.
         rsp_in.payload_address = (status_ff == ST_OK && !op_ff) ? addr_ff : '0;
         rsp_in.status          = status_ff;
         rsp_in.used_total      = used_ff;
         rsp_in.free_total      = free_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= HEAP_BASE_RESET;
         bytes_ff <= '0;
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         base_ff  <= base_in;
         bytes_ff <= bytes_in;
         count_ff <= count_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      reqb_ff      <= reqb_in;
      rel_ff       <= rel_in;
      size_ff      <= size_in;
      target_ff    <= target_in;
      zero_ff      <= zero_in;
      bad_ff       <= bad_in;
      idx_ff       <= idx_in;
      off_ff       <= off_in;
      prev_free_ff <= prev_free_in;
      prev_len_ff  <= prev_len_in;
      cur_len_ff   <= cur_len_in;
      merge_ff     <= merge_in;
      rem_ff       <= rem_in;
      removed_ff   <= removed_in;
      mdst_ff      <= mdst_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      addr_ff      <= addr_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      stat.is_free_op  = op_ff;
      stat.zero        = zero_ff;
      stat.big         = (size_ff > (LEN_W + 1)'(free_now));
      stat.bad         = bad_ff;
      stat.at_end      = (idx_ff == count_ff);
      stat.alloc_hit   = rd_seg.free && ((LEN_W + 1)'(rd_seg.len) >= size_ff);
      stat.addr_match  = (off_ff == target_ff);
      stat.rd_free     = rd_seg.free;
      stat.split_ok    = (WIDE_W'(cur_len_ff) >= WIDE_W'(size_ff) + HDR_W + GRAN_W)
                         && (count_ff < CNT_W'(SEG_DEPTH));
      stat.up_empty    = (count_ff <= idx_next);
      stat.up_last     = (src_ff == idx_next);
      stat.table_full  = (count_ff >= CNT_W'(SEG_DEPTH));
      stat.append_fits = (WIDE_W'(off_ff) + HDR_W + WIDE_W'(size_ff)) <= WIDE_W'(bytes_ff);
      stat.next_exists = (idx_next < count_ff);
      stat.down_empty  = (src_ff >= count_ff);
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/ffha_ctrl.sv
// Sequencer of the allocator: walks the segment table through the datapath,
// runs the shift passes and hands off the result word. Uses ffha_pkg.
`timescale 1ns / 1ps

module ffha_ctrl import ffha_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall
);

   typedef enum logic [18:0] {
      S_IDLE      = 19'b1 << 0,
      S_PREP      = 19'b1 << 1,
      S_CLASSIFY  = 19'b1 << 2,
      S_SCAN_RD   = 19'b1 << 3,
      S_SCAN_EV   = 19'b1 << 4,
      S_ALLOC_HIT = 19'b1 << 5,
      S_SHUP_RD   = 19'b1 << 6,
      S_SHUP_WR   = 19'b1 << 7,
      S_SPLIT_WR  = 19'b1 << 8,
      S_ALLOC_WR  = 19'b1 << 9,
      S_NOFIT     = 19'b1 << 10,
      S_FREE_HIT  = 19'b1 << 11,
      S_NEXT_RD   = 19'b1 << 12,
      S_NEXT_EV   = 19'b1 << 13,
      S_PREV_CHK  = 19'b1 << 14,
      S_MERGE_WR  = 19'b1 << 15,
      S_SHDN_RD   = 19'b1 << 16,
      S_SHDN_WR   = 19'b1 << 17,
      S_RESP      = 19'b1 << 18
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = ST_OK;
      cmd.rd_sel      = RS_IDX;
      cmd.wr_kind     = WK_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_CLASSIFY;
         end
         S_CLASSIFY: begin
            cmd.set_status = 1'b1;
            if (!stat.is_free_op && stat.zero) begin
               cmd.status_code = ST_ZERO_SIZE;
               state_in        = S_RESP;
            end else if (!stat.is_free_op && stat.big) begin
               cmd.status_code = ST_NO_MEMORY;
               state_in        = S_RESP;
            end else if (stat.is_free_op && stat.bad) begin
               cmd.status_code = ST_BAD_ADDR;
               state_in        = S_RESP;
            end else begin
               cmd.set_status = 1'b0;
               cmd.scan_init  = 1'b1;
               state_in       = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.at_end) begin
               if (stat.is_free_op) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_NOT_SEG;
                  state_in        = S_RESP;
               end else begin
                  state_in = S_NOFIT;
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            if (!stat.is_free_op && stat.alloc_hit) begin
               cmd.hit_latch  = 1'b1;
               cmd.addr_latch = 1'b1;
               state_in       = S_ALLOC_HIT;
            end else if (stat.is_free_op && stat.addr_match) begin
               if (stat.rd_free) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_DOUBLE;
                  state_in        = S_RESP;
               end else begin
                  cmd.hit_latch = 1'b1;
                  state_in      = S_FREE_HIT;
               end
            end else begin
               cmd.scan_adv = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_ALLOC_HIT: begin
            if (stat.split_ok) begin
               cmd.rem_latch     = 1'b1;
               cmd.shift_init_up = 1'b1;
               state_in          = stat.up_empty ? S_SPLIT_WR : S_SHUP_RD;
            end else begin
               cmd.wr_kind      = WK_ALLOC_CUR;
               cmd.used_add_cur = 1'b1;
               cmd.set_status   = 1'b1;
               state_in         = S_RESP;
            end
         end
         S_SHUP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RS_SRC;
            state_in   = S_SHUP_WR;
         end
         S_SHUP_WR: begin
            cmd.wr_kind = WK_SHIFT;
            if (stat.up_last) begin
               state_in = S_SPLIT_WR;
            end else begin
               cmd.shift_step_up = 1'b1;
               state_in          = S_SHUP_RD;
            end
         end
         S_SPLIT_WR: begin
            cmd.wr_kind = WK_REMAINDER;
            state_in    = S_ALLOC_WR;
         end
         S_ALLOC_WR: begin
            cmd.wr_kind       = WK_ALLOC_SZ;
            cmd.count_inc     = 1'b1;
            cmd.used_add_size = 1'b1;
            cmd.set_status    = 1'b1;
            state_in          = S_RESP;
         end
         S_NOFIT: begin
            cmd.set_status = 1'b1;
            state_in       = S_RESP;
            if (stat.table_full) begin
               cmd.status_code = ST_TABLE_FULL;
            end else if (!stat.append_fits) begin
               cmd.status_code = ST_NO_MEMORY;
            end else begin
               cmd.addr_latch    = 1'b1;
               cmd.wr_kind       = WK_APPEND;
               cmd.count_inc     = 1'b1;
               cmd.used_add_size = 1'b1;
            end
         end
         S_FREE_HIT: begin
            cmd.used_sub_cur = 1'b1;
            state_in         = stat.next_exists ? S_NEXT_RD : S_PREV_CHK;
         end
         S_NEXT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RS_NEXT;
            state_in   = S_NEXT_EV;
         end
         S_NEXT_EV: begin
            cmd.merge_next = 1'b1;
            state_in       = S_PREV_CHK;
         end
         S_PREV_CHK: begin
            cmd.merge_prev = 1'b1;
            state_in       = S_MERGE_WR;
         end
         S_MERGE_WR: begin
            cmd.wr_kind         = WK_MERGE;
            cmd.shift_init_down = 1'b1;
            state_in            = S_SHDN_RD;
         end
         S_SHDN_RD: begin
            if (stat.down_empty) begin
               cmd.count_sub  = 1'b1;
               cmd.set_status = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RS_SRC;
               state_in   = S_SHDN_WR;
            end
         end
         S_SHDN_WR: begin
            cmd.wr_kind         = WK_SHIFT;
            cmd.shift_step_down = 1'b1;
            state_in            = S_SHDN_RD;
         end
         S_RESP: begin
            // The previous word may still be waiting; load only once it has gone.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator: one allocate or free request in, one result word out.
// The block takes one request at a time. A request walks the table segment by segment,
// and copies every later entry when a split opens a slot or a free closes up the table
// behind the freed segment. The walk and the copies together cover the table at most
// once, and all of them go through the single read port of the segment table RAM.
// A finished result word is held in an output register, so the next request is taken
// while it waits. Configuration writes are always ready and should be made while idle.
// Uses ffha_pkg, ffha_ctrl and ffha_datapath.
`timescale 1ns / 1ps

module first_fit_heap_allocator import ffha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

   ffha_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_wr    (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for first_fit_heap_allocator: random and directed requests,
// checked word by word against a behavioural allocator held in a small scoreboard class.
// Depends on ffha_pkg and the RTL of first_fit_heap_allocator.
`timescale 1ns / 1ps

module tb_top;
   import ffha_pkg::*;

   localparam int WATCHDOG_CYCLES = 40000;
   localparam int PRESSURE_CYCLES = 400;
   localparam bit [63:0] HEAP_MAX = 64'd1 << 40;

   // Behavioural allocator plus the queue of words still to come back.
   class heap_scoreboard;
      bit [LEN_W-1:0] seg_len [SEG_DEPTH];
      bit             seg_free[SEG_DEPTH];
      int             seg_cnt;
      bit [63:0]      used;
      bit [63:0]      base;
      bit [63:0]      bytes;
      rsp_type        want_q[$];
      int             errors;

      function new();
         seg_cnt = 0;
         used    = 0;
         base    = 64'(HEAP_BASE_RESET);
         bytes   = 0;
         errors  = 0;
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] exp);
         $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
         errors++;
      endtask

      function bit [63:0] avail();
         return (bytes > used) ? bytes - used : 64'd0;
      endfunction

      function bit [63:0] seg_addr(int idx);
         bit [63:0] off;
         off = 0;
         for (int j = 0; j < idx; j++) off += HEADER_BYTES + seg_len[j];
         return base + off + HEADER_BYTES;
      endfunction

      function void drop_entry(int idx);
         for (int j = idx; j < seg_cnt - 1; j++) begin
            seg_len[j]  = seg_len[j+1];
            seg_free[j] = seg_free[j+1];
         end
         seg_cnt--;
      endfunction

      function status_type allocate(bit [63:0] req, output bit [63:0] addr);
         bit [63:0] size;
         bit [63:0] off;
         off  = 0;
         addr = 0;
         if (req == 0) return ST_ZERO_SIZE;
         size = ((req + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
         if (size > avail()) return ST_NO_MEMORY;
         for (int i = 0; i < seg_cnt; i++) begin
            if (seg_free[i] && seg_len[i] >= size) begin
               if (seg_len[i] >= size + HEADER_BYTES + GRANULE_BYTES
                   && seg_cnt < SEG_DEPTH) begin
                  for (int j = seg_cnt; j > i + 1; j--) begin
                     seg_len[j]  = seg_len[j-1];
                     seg_free[j] = seg_free[j-1];
                  end
                  seg_len[i+1]  = LEN_W'(seg_len[i] - size - HEADER_BYTES);
                  seg_free[i+1] = 1'b1;
                  seg_cnt++;
                  seg_len[i] = LEN_W'(size);
               end
               seg_free[i] = 1'b0;
               used = (used + HEADER_BYTES + seg_len[i]) & ((64'd1 << LEN_W) - 1);
               addr = base + off + HEADER_BYTES;
               return ST_OK;
            end
            off += HEADER_BYTES + seg_len[i];
         end
         if (seg_cnt >= SEG_DEPTH) return ST_TABLE_FULL;
         if (off + HEADER_BYTES + size > bytes) return ST_NO_MEMORY;
         seg_len[seg_cnt]  = LEN_W'(size);
         seg_free[seg_cnt] = 1'b0;
         seg_cnt++;
         used = (used + HEADER_BYTES + size) & ((64'd1 << LEN_W) - 1);
         addr = base + off + HEADER_BYTES;
         return ST_OK;
      endfunction

      function status_type release_seg(bit [63:0] rel);
         bit [63:0] off;
         bit [63:0] give;
         int        i;
         off = 0;
         if (rel == 0 || rel < base + HEADER_BYTES || rel >= base + bytes)
            return ST_BAD_ADDR;
         for (i = 0; i < seg_cnt; i++) begin
            if (base + off + HEADER_BYTES == rel) break;
            off += HEADER_BYTES + seg_len[i];
         end
         if (i >= seg_cnt) return ST_NOT_SEG;
         if (seg_free[i]) return ST_DOUBLE;
         seg_free[i] = 1'b1;
         give = HEADER_BYTES + seg_len[i];
         used = (used > give) ? used - give : 64'd0;
         if (i + 1 < seg_cnt && seg_free[i+1]) begin
            seg_len[i] = LEN_W'(seg_len[i] + HEADER_BYTES + seg_len[i+1]);
            drop_entry(i + 1);
         end
         if (i > 0 && seg_free[i-1]) begin
            seg_len[i-1] = LEN_W'(seg_len[i-1] + HEADER_BYTES + seg_len[i]);
            drop_entry(i);
         end
         return ST_OK;
      endfunction

      function void set_reg(csr_index_type idx, bit [63:0] value);
         if (idx == CSR_HEAP_BASE) base = value & ((64'd1 << ADDR_W) - 1);
         else bytes = value & ((64'd1 << LEN_W) - 1);
      endfunction

      // Works out the word an accepted request must produce and returns its status.
      function status_type note_request(req_type r);
         rsp_type    w;
         bit [63:0]  addr;
         status_type st;
         if (r.operation == 1'b0) st = allocate(64'(r.request_bytes), addr);
         else begin
            st   = release_seg(64'(r.release_address));
            addr = 0;
         end
         w.payload_address = (st == ST_OK) ? ADDR_W'(addr) : '0;
         w.status          = st;
         w.used_total      = LEN_W'(used);
         w.free_total      = LEN_W'(avail());
         want_q.push_back(w);
         return st;
      endfunction

      task check_result(rsp_type got);
         rsp_type w;
         if (want_q.size() == 0) begin
            report("unexpected word", 64'(got), 64'd0);
         end else begin
            w = want_q.pop_front();
            if (got.payload_address !== w.payload_address)
               report("payload_address", 64'(got.payload_address), 64'(w.payload_address));
            if (got.status !== w.status)
               report("status", 64'(got.status), 64'(w.status));
            if (got.used_total !== w.used_total)
               report("used_total", 64'(got.used_total), 64'(w.used_total));
            if (got.free_total !== w.free_total)
               report("free_total", 64'(got.free_total), 64'(w.free_total));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_index;
   logic [ADDR_W-1:0] csr_wdata;

   heap_scoreboard sb = new();
   logic           hold_off_req;
   int             idle_cycles;

   first_fit_heap_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Waits out the gap, offers the word and holds it until it is taken.
   task automatic send_req(req_type r, int gap, output status_type st);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      st = sb.note_request(r);
   endtask

   task automatic alloc_req(bit [63:0] n, int gap, output status_type st);
      req_type r;
      r.operation       = 1'b0;
      r.request_bytes   = LEN_W'(n);
      r.release_address = ADDR_W'($urandom());
      send_req(r, gap, st);
   endtask

   task automatic free_req(bit [63:0] a, int gap, output status_type st);
      req_type r;
      r.operation       = 1'b1;
      r.request_bytes   = LEN_W'({$urandom(), $urandom()});
      r.release_address = ADDR_W'(a);
      send_req(r, gap, st);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.want_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, bit [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= ADDR_W'(value);
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly allocates and frees of real segments, with some noise addresses and sizes.
   task automatic random_phase(int n, bit [63:0] size_cap);
      int         r;
      status_type st;
      bit [63:0]  v;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            v = (r < 4) ? {$urandom(), $urandom()} & ((64'd1 << LEN_W) - 1)
                        : $urandom_range(1, int'(size_cap));
            if (r == 4) v = 0;
            alloc_req(v, pick_gap(), st);
         end else if (r < 88 && sb.seg_cnt > 0) begin
            free_req(sb.seg_addr($urandom_range(0, sb.seg_cnt - 1)), pick_gap(), st);
         end else begin
            v = {$urandom(), $urandom()};
            if (r >= 95) v = sb.base + $urandom_range(0, 600);
            free_req(v, pick_gap(), st);
         end
      end
   endtask

   // Result side: random stalls, plus one long hold-off when asked for.
   initial begin : result_side
      int stall_left;
      int hold_left;
      bit stalling;
      bit hold_done;
      stall_left = 0;
      hold_left  = 0;
      stalling   = 1'b0;
      hold_done  = 1'b0;
      rsp_stall  = 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_result(rsp_data);
         if (hold_off_req && !hold_done) begin
            hold_left = PRESSURE_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (stall_left == 0) begin
               stalling   = ($urandom_range(0, 1) == 1);
               stall_left = stalling ? pick_gap() + 1 : $urandom_range(1, 30);
            end
            stall_left--;
            rsp_stall <= stalling;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_CYCLES) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      status_type st;
      bit [63:0]  a0;
      bit [63:0]  a1;
      bit [63:0]  a2;
      hold_off_req = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_HEAP_BASE;
      csr_wdata    = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: an empty heap refuses everything.
      alloc_req(0, 0, st);
      alloc_req(1, 0, st);
      free_req(0, 0, st);
      free_req(64'(HEAP_BASE_RESET) + HEADER_BYTES, 0, st);
      drain();

      write_reg(CSR_HEAP_BASE, 64'h1000);
      write_reg(CSR_HEAP_BYTES, 4096);
      alloc_req(1, 0, st);
      a0 = sb.seg_addr(0);
      alloc_req(40, 1, st);
      a1 = sb.seg_addr(1);
      alloc_req(100, 0, st);
      a2 = sb.seg_addr(2);
      alloc_req((64'd1 << LEN_W) - 1, 0, st);
      free_req((64'd1 << ADDR_W) - 1, 0, st);
      free_req(64'h1000 + HEADER_BYTES - 1, 0, st);
      free_req(64'h1000 + 4096, 0, st);
      free_req(a0 + 1, 0, st);
      free_req(a1, 0, st);
      free_req(a1, 0, st);
      alloc_req(16, 0, st);
      free_req(a0, 2, st);
      free_req(a2, 0, st);
      free_req(sb.seg_addr(0), 0, st);
      alloc_req(3000, 0, st);
      alloc_req(400, 0, st);
      alloc_req(2000, 0, st);
      free_req(sb.seg_addr(0), 0, st);
      alloc_req(64, 0, st);
      drain();

      random_phase(60, 300);
      drain();

      write_reg(CSR_HEAP_BASE, 0);
      write_reg(CSR_HEAP_BYTES, 3000);
      hold_off_req <= 1'b1;
      random_phase(20, 200);
      hold_off_req <= 1'b0;
      random_phase(40, 200);
      drain();

      write_reg(CSR_HEAP_BASE, (64'd1 << ADDR_W) - 64);
      write_reg(CSR_HEAP_BYTES, 0);
      random_phase(15, 100);
      drain();

      write_reg(CSR_HEAP_BASE, {$urandom(), $urandom()} & ((64'd1 << 47) - 1));
      write_reg(CSR_HEAP_BYTES, HEAP_MAX);
      random_phase(70, 4000);
      drain();

      write_reg(CSR_HEAP_BASE, {$urandom(), $urandom()} & ((64'd1 << 40) - 1));
      write_reg(CSR_HEAP_BYTES, $urandom_range(1024, 16384));
      random_phase(70, 600);
      drain();

      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.want_q.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
